### rtl/core/array_literal_parser_assert.svh
// ---------------------------------------------------------------------------
// Array literal parser assertion macros
// Clocked and reset-gated assertion wrappers used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ARRAY_LITERAL_PARSER_ASSERT_SVH
`define ARRAY_LITERAL_PARSER_ASSERT_SVH

// plain implication property under clock and active-low reset
`define ALP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// hold check: when cond held in the previous cycle, sig must not change
`define ALP_ASSERT_HOLD(lbl, clk, rst_n, cond, sig, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) \
		(cond) |=> $stable(sig)) else $error(msg);

`endif

### rtl/core/alp_pkg.sv
// ---------------------------------------------------------------------------
// Array literal parser package
// Character constants, phase codes, result kinds, error codes and the decode result bundle.
// ---------------------------------------------------------------------------
package alp_pkg;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef enum logic [3:0] {
		PH_START  = 4'd0,
		PH_OPENED = 4'd1,
		PH_ELEM   = 4'd2,
		PH_UNQ    = 4'd3,
		PH_QUOTED = 4'd4,
		PH_ESCAPE = 4'd5,
		PH_QEND   = 4'd6,
		PH_CLOSED = 4'd7,
		PH_DRAIN  = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		K_BYTE = 2'd0,
		K_END  = 2'd1,
		K_DONE = 2'd2,
		K_ERR  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		E_NO_OPEN     = 3'd0,
		E_ESC_END     = 3'd1,
		E_NO_QUOTE    = 3'd2,
		E_NO_SEP      = 3'd3,
		E_NO_CLOSE    = 3'd4,
		E_OPEN        = 3'd5,
		E_TRAILING    = 3'd6,
		E_NONE        = 3'd7
	} err_t;

	typedef struct packed {
		logic        emit;
		logic [1:0]  kind;
		logic [7:0]  data;
		logic [2:0]  err_code;
		phase_t      next;
	} dec_t;

endpackage

### rtl/core/alp_if.sv
// ---------------------------------------------------------------------------
// Array literal parser channels
// Valid/ready channels for literal bytes and for parse results.
// ---------------------------------------------------------------------------
interface alp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

interface alp_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data;
	logic [2:0] err_code;

	modport source (output valid, output kind, output data, output err_code, input ready);
	modport sink (input valid, input kind, input data, input err_code, output ready);
endinterface

### rtl/core/alp_decode.sv
// ---------------------------------------------------------------------------
// Array literal parser byte decode
// Next phase and result for one byte in the current phase.
// ---------------------------------------------------------------------------
module alp_decode
	import alp_pkg::*;
(
	input  phase_t     phase,
	input  logic [7:0] ch,
	output dec_t       dec
);

	logic is_nul;

	assign is_nul = (ch == CH_NUL);

	always_comb begin
		dec.emit     = 1'b0;
		dec.kind     = K_BYTE;
		dec.data     = 8'h00;
		dec.err_code = 3'd0;
		dec.next     = phase;
		unique case (phase)
			PH_START: begin
				if (is_nul) begin
					dec.emit = 1'b1;
					dec.kind = K_DONE;
				end else if (ch == CH_LBRACE) begin
					dec.next = PH_OPENED;
				end else begin
					dec.emit     = 1'b1;
					dec.kind     = K_ERR;
					dec.err_code = E_NO_OPEN;
					dec.next     = PH_DRAIN;
				end
			end
			PH_OPENED, PH_ELEM: begin
				priority if (ch == CH_QUOTE) begin
					dec.next = PH_QUOTED;
				end else if (is_nul) begin
					dec.emit     = 1'b1;
					dec.kind     = K_ERR;
					dec.err_code = E_NO_CLOSE;
					dec.next     = PH_START;
				end else if (ch == CH_LBRACE) begin
					dec.emit     = 1'b1;
					dec.kind     = K_ERR;
					dec.err_code = E_OPEN;
					dec.next     = PH_DRAIN;
				end else if (ch == CH_RBRACE) begin
					dec.next = PH_CLOSED;
					dec.emit = (phase == PH_ELEM);
					dec.kind = K_END;
				end else if (ch == CH_COMMA) begin
					dec.next = PH_ELEM;
					dec.emit = 1'b1;
					dec.kind = K_END;
				end else begin
					dec.next = PH_UNQ;
					dec.emit = 1'b1;
					dec.data = ch;
				end
			end
			PH_UNQ: begin
				priority if (ch == CH_COMMA) begin
					dec.next = PH_ELEM;
					dec.emit = 1'b1;
					dec.kind = K_END;
				end else if (ch == CH_RBRACE) begin
					dec.next = PH_CLOSED;
					dec.emit = 1'b1;
					dec.kind = K_END;
				end else if (is_nul) begin
					dec.emit     = 1'b1;
					dec.kind     = K_ERR;
					dec.err_code = E_NO_CLOSE;
					dec.next     = PH_START;
				end else begin
					dec.emit = 1'b1;
					dec.data = ch;
				end
			end
			PH_QUOTED: begin
				priority if (ch == CH_QUOTE) begin
					dec.next = PH_QEND;
				end else if (ch == CH_BSLASH) begin
					dec.next = PH_ESCAPE;
				end else if (is_nul) begin
					dec.emit     = 1'b1;
					dec.kind     = K_ERR;
					dec.err_code = E_NO_QUOTE;
					dec.next     = PH_START;
				end else begin
					dec.emit = 1'b1;
					dec.data = ch;
				end
			end
			PH_ESCAPE: begin
				dec.emit = 1'b1;
				if (is_nul) begin
					dec.kind     = K_ERR;
					dec.err_code = E_ESC_END;
					dec.next     = PH_START;
				end else begin
					dec.data = ch;
					dec.next = PH_QUOTED;
				end
			end
			PH_QEND: begin
				dec.emit = 1'b1;
				priority if (ch == CH_COMMA) begin
					dec.kind = K_END;
					dec.next = PH_ELEM;
				end else if (ch == CH_RBRACE) begin
					dec.kind = K_END;
					dec.next = PH_CLOSED;
				end else begin
					dec.kind     = K_ERR;
					dec.err_code = E_NO_SEP;
					dec.next     = is_nul ? PH_START : PH_DRAIN;
				end
			end
			PH_CLOSED: begin
				dec.emit = 1'b1;
				if (is_nul) begin
					dec.kind = K_DONE;
					dec.next = PH_START;
				end else begin
					dec.kind     = K_ERR;
					dec.err_code = E_TRAILING;
					dec.next     = PH_DRAIN;
				end
			end
			default: begin
				dec.next = is_nul ? PH_START : PH_DRAIN;
			end
		endcase
	end

endmodule

### rtl/core/array_literal_parser.sv
// ---------------------------------------------------------------------------
// Array literal parser
// Decodes a one-dimensional array literal, one byte per transaction.
// ---------------------------------------------------------------------------
//  channel | dir | payload               | note
//  lit     | in  | ch[7:0]               | zero byte ends a string
//  res     | out | kind, data, err_code  | at most one per input byte
//
//  One byte per cycle sustained while a held result does not stall lit.
//  A byte sits in the input register while its phase is decoded; the
//  result register holds a transaction until res.ready.
//  Reset returns the phase to the start of a string and empties both
//  registers. A held result stalls lit only when the next byte also
//  produces a result.
module array_literal_parser
	import alp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	alp_byte_if.sink      lit,
	alp_res_if.source     res
);

	phase_t     phase_q;
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       out_valid_q;
	logic [1:0] kind_q;
	logic [7:0] data_q;
	logic [2:0] err_code_q;
	dec_t       dec;
	logic       stall;
	logic       advance;

	alp_decode u_decode (
		.phase (phase_q),
		.ch    (ch_s1),
		.dec   (dec)
	);

	assign stall   = valid_s1 && dec.emit && out_valid_q && !res.ready;
	assign advance = valid_s1 && !stall;

	assign lit.ready    = !valid_s1 || !stall;
	assign res.valid    = out_valid_q;
	assign res.kind     = kind_q;
	assign res.data     = data_q;
	assign res.err_code = err_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (lit.ready) begin
				valid_s1 <= lit.valid;
			end
			if (advance) begin
				phase_q <= dec.next;
			end
			out_valid_q <= (out_valid_q && !res.ready) || (advance && dec.emit);
		end
	end

	always_ff @(posedge clk) begin
		if (lit.valid && lit.ready) begin
			ch_s1 <= lit.ch;
		end
		if (advance && dec.emit) begin
			kind_q     <= dec.kind;
			data_q     <= dec.data;
			err_code_q <= dec.err_code;
		end
	end

endmodule

### rtl/core/alp_checker.sv
// ---------------------------------------------------------------------------
// Array literal parser checker
// Port-level checks on result transactions, bound to the top level.
// ---------------------------------------------------------------------------
`include "array_literal_parser_assert.svh"

module alp_checker
	import alp_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] res_kind,
	input logic [7:0] res_data,
	input logic [2:0] res_err_code
);

	`ALP_ASSERT_HOLD(a_res_hold, clk, arst_n, res_valid && !res_ready, {res_valid, res_kind, res_data, res_err_code}, "result changed while stalled")
	`ALP_ASSERT(a_data_zero, clk, arst_n, res_valid && (res_kind != K_BYTE) |-> (res_data == 8'h00), "data set on a non-byte result")
	`ALP_ASSERT(a_err_zero, clk, arst_n, res_valid && (res_kind != K_ERR) |-> (res_err_code == 3'd0), "error code set on a non-error result")
	`ALP_ASSERT(a_err_range, clk, arst_n, res_valid && (res_kind == K_ERR) |-> (res_err_code != E_NONE), "error code out of range")

endmodule

bind array_literal_parser alp_checker u_alp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.res_kind     (res.kind),
	.res_data     (res.data),
	.res_err_code (res.err_code)
);

### sim/array_literal_parser_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Array literal parser testbench
// Streams zero-terminated array literals into the parser. Each accepted byte
// goes through a phase-tracking decoder kept here, and the element bytes,
// element ends, done and error codes it expects are queued in order. Each
// result the parser hands over is compared field by field with the oldest
// queued one. Stimulus is a short directed set, then random well-formed
// arrays, damaged arrays and noise. Both channels idle in random bursts.
// ---------------------------------------------------------------------------
module array_literal_parser_test;
	import alp_pkg::*;

	localparam logic [2:0] ERR_CLEAR = 3'd0;

	typedef struct {
		kind_t      kind;
		logic [7:0] data;
		logic [2:0] err_code;
	} parse_result_t;

	logic clk;
	logic arst_n;

	alp_byte_if lit ();
	alp_res_if  res ();

	array_literal_parser DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.lit    (lit),
		.res    (res)
	);

	logic [7:0]    lit_bytes[$];
	parse_result_t pending_results[$];
	phase_t        lit_phase;
	logic          lit_taken;
	int            errors_seen;
	int            send_idle_pct;
	int            stall_pct;
	int            send_gap;
	int            stall_left;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function void post(kind_t k, logic [7:0] d, logic [2:0] e);
		parse_result_t r;
		r.kind = k;
		r.data = d;
		r.err_code = e;
		pending_results.insert(pending_results.size(), r);
	endfunction

	function void reject(logic [7:0] c, err_t code);
		lit_phase = (c == CH_NUL) ? PH_START : PH_DRAIN;
		post(K_ERR, 8'h00, code);
	endfunction

	function void open_element(logic [7:0] c, logic after_open);
		if (c == CH_QUOTE) begin
			lit_phase = PH_QUOTED;
		end else if (c == CH_NUL) begin
			reject(c, E_NO_CLOSE);
		end else if (c == CH_LBRACE) begin
			reject(c, E_OPEN);
		end else if (c == CH_RBRACE) begin
			lit_phase = PH_CLOSED;
			if (!after_open)
				post(K_END, 8'h00, ERR_CLEAR);
		end else if (c == CH_COMMA) begin
			lit_phase = PH_ELEM;
			post(K_END, 8'h00, ERR_CLEAR);
		end else begin
			lit_phase = PH_UNQ;
			post(K_BYTE, c, ERR_CLEAR);
		end
	endfunction

	function void decode_byte(logic [7:0] c);
		case (lit_phase)
			PH_START: begin
				if (c == CH_NUL)
					post(K_DONE, 8'h00, ERR_CLEAR);
				else if (c == CH_LBRACE)
					lit_phase = PH_OPENED;
				else
					reject(c, E_NO_OPEN);
			end
			PH_OPENED: open_element(c, 1'b1);
			PH_ELEM: open_element(c, 1'b0);
			PH_UNQ: begin
				if (c == CH_COMMA) begin
					lit_phase = PH_ELEM;
					post(K_END, 8'h00, ERR_CLEAR);
				end else if (c == CH_RBRACE) begin
					lit_phase = PH_CLOSED;
					post(K_END, 8'h00, ERR_CLEAR);
				end else if (c == CH_NUL) begin
					reject(c, E_NO_CLOSE);
				end else begin
					post(K_BYTE, c, ERR_CLEAR);
				end
			end
			PH_QUOTED: begin
				if (c == CH_QUOTE)
					lit_phase = PH_QEND;
				else if (c == CH_BSLASH)
					lit_phase = PH_ESCAPE;
				else if (c == CH_NUL)
					reject(c, E_NO_QUOTE);
				else
					post(K_BYTE, c, ERR_CLEAR);
			end
			PH_ESCAPE: begin
				if (c == CH_NUL) begin
					reject(c, E_ESC_END);
				end else begin
					lit_phase = PH_QUOTED;
					post(K_BYTE, c, ERR_CLEAR);
				end
			end
			PH_QEND: begin
				if (c == CH_COMMA) begin
					lit_phase = PH_ELEM;
					post(K_END, 8'h00, ERR_CLEAR);
				end else if (c == CH_RBRACE) begin
					lit_phase = PH_CLOSED;
					post(K_END, 8'h00, ERR_CLEAR);
				end else begin
					reject(c, E_NO_SEP);
				end
			end
			PH_CLOSED: begin
				if (c == CH_NUL) begin
					lit_phase = PH_START;
					post(K_DONE, 8'h00, ERR_CLEAR);
				end else begin
					reject(c, E_TRAILING);
				end
			end
			default: lit_phase = (c == CH_NUL) ? PH_START : PH_DRAIN;
		endcase
	endfunction

	task check_result();
		parse_result_t want;
		if (pending_results.size() == 0) begin
			$error("unexpected result: kind %0d data %0h err_code %0d",
				res.kind, res.data, res.err_code);
			errors_seen++;
		end else begin
			want = pending_results.pop_front();
			if (res.kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, res.kind);
				errors_seen++;
			end
			if (res.data !== want.data) begin
				$error("data: expected %0h, got %0h", want.data, res.data);
				errors_seen++;
			end
			if (res.err_code !== want.err_code) begin
				$error("err_code: expected %0d, got %0d", want.err_code, res.err_code);
				errors_seen++;
			end
		end
	endtask

	always @(posedge clk) begin
		lit_taken <= arst_n && lit.valid && lit.ready;
		if (arst_n) begin
			if (res.valid && res.ready)
				check_result();
			if (lit.valid && lit.ready)
				decode_byte(lit.ch);
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			lit.valid <= 1'b0;
		end else if (!lit.valid || lit_taken) begin
			if (send_gap > 0) begin
				lit.valid <= 1'b0;
				send_gap--;
			end else if (lit_bytes.size() != 0 && $urandom_range(0, 99) < send_idle_pct) begin
				lit.valid <= 1'b0;
				send_gap = $urandom_range(0, 3);
			end else if (lit_bytes.size() != 0) begin
				lit.valid <= 1'b1;
				lit.ch <= lit_bytes.pop_front();
			end else begin
				lit.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else if (stall_left > 0) begin
			res.ready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			res.ready <= 1'b0;
			stall_left = $urandom_range(0, 3);
		end else begin
			res.ready <= 1'b1;
		end
	end

	function void add_byte(logic [7:0] b);
		lit_bytes.insert(lit_bytes.size(), b);
	endfunction

	function void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endfunction

	function automatic logic [7:0] pick_special();
		case ($urandom_range(0, 6))
			0: return CH_LBRACE;
			1: return CH_RBRACE;
			2: return CH_COMMA;
			3: return CH_QUOTE;
			4: return CH_BSLASH;
			5: return CH_NUL;
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	function void add_element();
		int n;
		logic [7:0] b;
		n = $urandom_range(0, 6);
		if ($urandom_range(0, 1)) begin
			add_byte(CH_QUOTE);
			for (int i = 0; i < n; i++) begin
				b = 8'($urandom_range(1, 255));
				if (b == CH_QUOTE || b == CH_BSLASH || $urandom_range(0, 7) == 0)
					add_byte(CH_BSLASH);
				add_byte(b);
			end
			add_byte(CH_QUOTE);
		end else begin
			for (int i = 0; i < n; i++) begin
				do
					b = 8'($urandom_range(1, 255));
				while (b == CH_COMMA || b == CH_RBRACE ||
					(i == 0 && (b == CH_QUOTE || b == CH_LBRACE)));
				add_byte(b);
			end
		end
	endfunction

	function void add_array();
		int n;
		n = $urandom_range(0, 4);
		add_byte(CH_LBRACE);
		for (int i = 0; i < n; i++) begin
			if (i > 0)
				add_byte(CH_COMMA);
			add_element();
		end
		add_byte(CH_RBRACE);
		add_byte(CH_NUL);
	endfunction

	function void add_damaged_array();
		int first;
		int last;
		int pos;
		first = lit_bytes.size();
		add_array();
		last = lit_bytes.size() - 1;
		case ($urandom_range(0, 3))
			0: begin
				pos = $urandom_range(first + 1, last);
				lit_bytes[pos] = CH_NUL;
				while (lit_bytes.size() > pos + 1)
					void'(lit_bytes.pop_back());
			end
			1: begin
				pos = $urandom_range(first, last - 1);
				lit_bytes[pos] = pick_special();
			end
			2: begin
				pos = $urandom_range(first, last);
				lit_bytes.insert(pos, pick_special());
			end
			default: lit_bytes.insert(last, 8'($urandom_range(1, 255)));
		endcase
	endfunction

	function void add_noise();
		int n;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++)
			add_byte($urandom_range(0, 1) ? pick_special() : 8'($urandom_range(0, 255)));
		add_byte(CH_NUL);
	endfunction

	function void add_random_strings(int count);
		int pushed;
		int was;
		int r;
		pushed = 0;
		while (pushed < count) begin
			was = lit_bytes.size();
			r = $urandom_range(0, 99);
			if (r < 60)
				add_array();
			else if (r < 85)
				add_damaged_array();
			else
				add_noise();
			pushed += lit_bytes.size() - was;
		end
	endfunction

	task wait_all_results();
		while (lit_bytes.size() != 0 || lit.valid || pending_results.size() != 0)
			@(posedge clk);
	endtask

	task wait_all_sent();
		while (lit_bytes.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		lit.valid = 1'b0;
		lit.ch = 8'h00;
		res.ready = 1'b0;
		lit_taken = 1'b0;
		lit_phase = PH_START;
		errors_seen = 0;
		send_gap = 0;
		stall_left = 0;
		send_idle_pct = 20;
		stall_pct = 20;

		add_byte(CH_NUL);
		add_text("{}");
		add_byte(CH_NUL);
		add_text("{,}");
		add_byte(CH_NUL);
		add_text("{a\"{\\");
		add_byte(8'hFF);
		add_text("}");
		add_byte(CH_NUL);
		add_text("{\"\\\"\"}");
		add_byte(CH_NUL);
		add_text("x");
		add_byte(CH_NUL);
		add_text("{\"\\");
		add_byte(CH_NUL);
		add_text("{\"");
		add_byte(8'h01);
		add_text("\"x");
		add_byte(CH_NUL);

		repeat (12) @(posedge clk);
		#2 arst_n = 1'b1;
		wait_all_results();

		add_random_strings(250);
		wait_all_results();

		send_idle_pct = 0;
		stall_pct = 40;
		add_random_strings(150);
		wait_all_sent();

		send_idle_pct = 40;
		stall_pct = 0;
		add_random_strings(150);
		wait_all_sent();

		send_idle_pct = 0;
		stall_pct = 0;
		add_random_strings(100);
		wait_all_results();
		repeat (8) @(posedge clk);

		if (errors_seen == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
